@@ design/smt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIXEL_W   = 8;
    localparam int CFG_W     = 11;
    localparam int GRAD_W    = 11;
    localparam int MAG_W     = 21;
    localparam int THR_SQ_W  = 22;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;
    localparam int QUEUE_DEPTH = 2;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH    = 1'b0;
    localparam logic REG_EDGE_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST    = 11'd640;
    localparam logic [CFG_W-1:0] EDGE_THRESHOLD_RST = 11'd275;

    // interior window handed from front to back; the center pixel has no weight
    typedef struct packed {
        logic [PIXEL_W-1:0] p00;
        logic [PIXEL_W-1:0] p01;
        logic [PIXEL_W-1:0] p02;
        logic [PIXEL_W-1:0] p10;
        logic [PIXEL_W-1:0] p12;
        logic [PIXEL_W-1:0] p20;
        logic [PIXEL_W-1:0] p21;
        logic [PIXEL_W-1:0] p22;
        logic               last;
    } win_t;

endpackage

`default_nettype wire

@@ design/sobel_magnitude_threshold.sv @@
// Sobel 3x3 edge detector. Gray pixels arrive in raster order, one word per
// clock while s_tready is high, on the s_ stream (tuser = frame start, tlast =
// frame end); one word leaves on the m_ stream for every interior pixel, one
// row and one column behind the input, carrying grad_x, grad_y and grad_x^2 +
// grad_y^2 in tdata, the edge flag (magnitude squared >= threshold squared) in
// tuser and the frame end of the causing pixel in tlast. Border pixels produce
// nothing. The block sustains one pixel per clock unless the output stalls: the
// two previous rows sit in a single dual-port line RAM read and written once per
// pixel, so the line RAM port sets the rate. A result word passes the input
// register, the two-entry queue and the gradient pipeline registers; the queue
// lets the window front end and the gradient pipeline stall alone. The user must
// write image_width (0x0) and edge_threshold (0x4) over APB only while the stream
// is idle; the block does not enforce this. Widths below 3 act as 3 and widths
// above MAX_WIDTH act as MAX_WIDTH. The line RAM has no reset and no clearing
// pass: it fills during the first two rows.
`timescale 1ns / 1ps
`default_nettype none

module sobel_magnitude_threshold
    import smt_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] pixel_value
    input  wire logic                  s_tuser,   // [0] frame_start
    input  wire logic                  s_tlast,   // frame_end

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // [10:0] grad_x, [21:11] grad_y,
                                                  // [42:22] magnitude_sq, [47:43] zero
    output logic                       m_tuser,   // [0] edge_flag
    output logic                       m_tlast    // last_of_frame
);

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] edge_threshold_reg;
    logic             cfg_write;

    logic             push;
    win_t             push_data;
    logic             queue_full;
    logic             win_valid;
    logic             win_pop;
    win_t             win;

    logic signed [GRAD_W-1:0] grad_x, grad_y;
    logic        [MAG_W-1:0]  magnitude_sq;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= IMAGE_WIDTH_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_IMAGE_WIDTH:    image_width_reg    <= pwdata[CFG_W-1:0];
                REG_EDGE_THRESHOLD: edge_threshold_reg <= pwdata[CFG_W-1:0];
                default:            image_width_reg    <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IMAGE_WIDTH:    prdata = APB_DATA_W'(image_width_reg);
            REG_EDGE_THRESHOLD: prdata = APB_DATA_W'(edge_threshold_reg);
            default:            prdata = '0;
        endcase
    end

    smt_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_width (image_width_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pixel_value (s_tdata[PIXEL_W-1:0]),
        .frame_start (s_tuser),
        .frame_end   (s_tlast),
        .push        (push),
        .push_data   (push_data),
        .queue_full  (queue_full)
    );

    smt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop_valid (win_valid),
        .pop       (win_pop),
        .pop_data  (win)
    );

    smt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .edge_threshold (edge_threshold_reg),
        .win_valid      (win_valid),
        .win_pop        (win_pop),
        .win            (win),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .grad_x         (grad_x),
        .grad_y         (grad_y),
        .magnitude_sq   (magnitude_sq),
        .edge_flag      (m_tuser),
        .last_of_frame  (m_tlast)
    );

    assign m_tdata = {(OUT_DATA_W - 2 * GRAD_W - MAG_W)'(0), magnitude_sq, grad_y, grad_x};

endmodule

`default_nettype wire

@@ design/smt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/smt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smt_front
    import smt_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CFG_W-1:0]   image_width,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [PIXEL_W-1:0] pixel_value,
    input  wire logic               frame_start,
    input  wire logic               frame_end,
    output logic                    push,
    output win_t                    push_data,
    input  wire logic               queue_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int LW = 2 * PIXEL_W;

    logic [WW-1:0] width_ext;
    logic [WW-1:0] eff_width;
    logic [CW-1:0] last_col;

    logic [CW-1:0] col_reg, col_next, col_cur;
    logic [1:0]    row_reg, row_next, row_cur;

    logic               s1_valid_reg;
    logic               s1_emit_reg;
    logic               s1_end_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               byp_reg;
    logic [LW-1:0]      byp_data_reg;

    logic               in_fire;
    logic               s1_fire;
    logic [LW-1:0]      ram_q;
    logic [LW-1:0]      line_q;
    logic [PIXEL_W-1:0] top_px, mid_px;
    logic [LW-1:0]      line_wdata;

    logic [PIXEL_W-1:0] win_reg  [9];
    logic [PIXEL_W-1:0] win_next [9];

    always_comb
    begin
        width_ext = WW'(image_width);
        if (width_ext < WW'(3))
        begin
            eff_width = WW'(3);
        end
        else if (width_ext > WW'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
        last_col = CW'(eff_width - WW'(1));
    end

    assign s1_fire  = s1_valid_reg && (!s1_emit_reg || !queue_full);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    // frame start clears the counters before this pixel is placed
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? 2'd0 : row_reg;

    always_comb
    begin
        if (frame_end)
        begin
            col_next = '0;
            row_next = 2'd0;
        end
        else if (col_cur >= last_col)
        begin
            col_next = '0;
            row_next = (row_cur == 2'd2) ? 2'd2 : row_cur + 2'd1;
        end
        else
        begin
            col_next = col_cur + CW'(1);
            row_next = row_cur;
        end
    end

    // both line stores share one word: previous-previous row high, previous row low
    smt_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (in_fire),
        .raddr (col_cur),
        .rdata (ram_q)
    );

    assign line_q     = byp_reg ? byp_data_reg : ram_q;
    assign top_px     = line_q[LW-1:PIXEL_W];
    assign mid_px     = line_q[PIXEL_W-1:0];
    assign line_wdata = {mid_px, s1_px_reg};

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top_px;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid_px;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_px_reg;
    end

    assign push = s1_fire && s1_emit_reg;

    always_comb
    begin
        push_data.p00  = win_next[0];
        push_data.p01  = win_next[1];
        push_data.p02  = win_next[2];
        push_data.p10  = win_next[3];
        push_data.p12  = win_next[5];
        push_data.p20  = win_next[6];
        push_data.p21  = win_next[7];
        push_data.p22  = win_next[8];
        push_data.last = s1_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= 2'd0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            byp_reg      <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_fire)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
                s1_emit_reg  <= (row_cur == 2'd2) && (col_cur >= CW'(2));
                // forward the line word being written this edge to a read of the same column
                byp_reg      <= s1_fire && (s1_col_reg == col_cur);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg    <= pixel_value;
            s1_end_reg   <= frame_end;
            s1_col_reg   <= col_cur;
            byp_data_reg <= line_wdata;
        end
    end

endmodule

`default_nettype wire

@@ design/smt_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smt_queue
    import smt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  win_t      push_data,
    output logic      full,
    output logic      pop_valid,
    input  wire logic pop,
    output win_t      pop_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    win_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg, count_next;
    logic            do_pop;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ design/smt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smt_back
    import smt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [CFG_W-1:0]        edge_threshold,
    input  wire logic                    win_valid,
    output logic                         win_pop,
    input  win_t                         win,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [GRAD_W-1:0]     grad_x,
    output logic signed [GRAD_W-1:0]     grad_y,
    output logic        [MAG_W-1:0]      magnitude_sq,
    output logic                         edge_flag,
    output logic                         last_of_frame
);

    localparam int SW = GRAD_W - 1;

    logic [THR_SQ_W-1:0] thr_ext;
    logic [THR_SQ_W-1:0] thr_sq_reg;

    logic [SW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;

    logic                     v1_reg, v2_reg, v3_reg;
    logic                     rdy1, rdy2, rdy3;
    logic signed [GRAD_W-1:0] gx1_reg, gy1_reg, gx2_reg, gy2_reg;
    logic                     last1_reg, last2_reg;
    logic signed [2*GRAD_W-1:0] gx_prod, gy_prod;
    logic [MAG_W-1:0]         sqx_reg, sqy_reg;
    logic [MAG_W-1:0]         mag_sum;

    logic signed [GRAD_W-1:0] gx_out_reg, gy_out_reg;
    logic [MAG_W-1:0]         mag_out_reg;
    logic                     edge_out_reg, last_out_reg;

    assign thr_ext = THR_SQ_W'(edge_threshold);

    // elastic pipeline: a stage moves when the one after it is empty or moving
    assign rdy3    = !v3_reg || out_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign win_pop = win_valid && rdy1;

    assign gx_pos = SW'(win.p02) + SW'({win.p12, 1'b0}) + SW'(win.p22);
    assign gx_neg = SW'(win.p00) + SW'({win.p10, 1'b0}) + SW'(win.p20);
    assign gy_pos = SW'(win.p20) + SW'({win.p21, 1'b0}) + SW'(win.p22);
    assign gy_neg = SW'(win.p00) + SW'({win.p01, 1'b0}) + SW'(win.p02);

    assign gx_prod = gx1_reg * gx1_reg;
    assign gy_prod = gy1_reg * gy1_reg;
    assign mag_sum = sqx_reg + sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= win_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        thr_sq_reg <= thr_ext * thr_ext;
        if (win_pop)
        begin
            gx1_reg   <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
            gy1_reg   <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
            last1_reg <= win.last;
        end
        if (rdy2 && v1_reg)
        begin
            sqx_reg   <= MAG_W'(gx_prod);
            sqy_reg   <= MAG_W'(gy_prod);
            gx2_reg   <= gx1_reg;
            gy2_reg   <= gy1_reg;
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            gx_out_reg   <= gx2_reg;
            gy_out_reg   <= gy2_reg;
            mag_out_reg  <= mag_sum;
            edge_out_reg <= ({1'b0, mag_sum} >= thr_sq_reg);
            last_out_reg <= last2_reg;
        end
    end

    assign out_valid     = v3_reg;
    assign grad_x        = gx_out_reg;
    assign grad_y        = gy_out_reg;
    assign magnitude_sq  = mag_out_reg;
    assign edge_flag     = edge_out_reg;
    assign last_of_frame = last_out_reg;

endmodule

`default_nettype wire
